// ----- hdl/mpf_pkg.sv -----
// ============================================================================
// mpf_pkg: shared types and constants of the multi-turn position fusion unit
// Request and result payload types, register indexes, reset values and fixed widths.
// ============================================================================
`default_nettype none

package mpf_pkg;

    // Field widths fixed by the sensor formats.
    localparam int SAMPLE_W   = 12;
    localparam int ANGLE_W    = 12;
    localparam int COARSE_W   = 13;
    localparam int POS_W      = 25;
    localparam int TURNS_W    = POS_W - ANGLE_W - 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_POT_ZERO       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENC_ZERO       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SPAN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POT_REVERSE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = 3'd4;

    localparam logic [COARSE_W-1:0] TURN_SPAN_RESET      = 13'd512;
    localparam logic [COARSE_W-1:0] WRAP_THRESHOLD_RESET = 13'd4000;

    // Fixed levels of the turn selection.
    localparam logic [COARSE_W-1:0] FULL_SCALE   = 13'd4096;
    localparam logic [COARSE_W-1:0] LOW_COARSE   = 13'd100;
    localparam logic [COARSE_W-1:0] HOLD_COARSE  = 13'd10;
    localparam logic [ANGLE_W-1:0]  ANGLE_LOW    = 12'd1024;
    localparam logic [ANGLE_W-1:0]  ANGLE_HIGH   = 12'd3072;
    localparam int                  SAMPLE_MAX   = 4095;

    // Defaults for the module parameters.
    localparam int WINDOW_LEN_DEFAULT = 8;
    localparam int DIV_W_DEFAULT      = 15;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pot_sample;
        logic [ANGLE_W-1:0]  enc_angle;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [COARSE_W-1:0]     coarse_count;
    } out_item_t;

endpackage : mpf_pkg

`default_nettype wire

// ----- hdl/multiturn_position_fusion_unit.sv -----
// ============================================================================
// multiturn_position_fusion_unit: potentiometer and encoder position fusion
// Combines a filtered multi-turn potentiometer count with a single-turn
// magnetic encoder angle into one absolute multi-turn position.
// ============================================================================
//
// Usage:
//   A request on the s_ channel carries one potentiometer sample and one
//   encoder angle. Each request produces exactly one result on the m_ channel:
//   the absolute position and the filtered coarse count. Requests are worked
//   on one at a time. The potentiometer window lives in a small synchronous
//   memory used as a ring buffer; the turn number comes from a serial
//   divider that resolves one quotient bit per cycle.
//   A request steps through the states read, average, coarse, divide and
//   emit; the divider width is the larger of the window sum width and 13.
//   Cases that skip the divider (near wrap, or a low coarse count with a
//   high angle) go from coarse straight to emit. The window average is a
//   shift, or a reciprocal multiply for a length that is not a power of
//   two, registered in its own state. s_ready rises on the edge that loads
//   a result. The result sits in an output register; while the receiver
//   stalls the unit holds the next finished result and takes no new
//   request. Reset (aresetn low, synchronous) restores the register
//   defaults, empties the window and clears the held position.
//   Configuration writes are always taken and must only be issued while
//   the unit is idle.
//
`default_nettype none

module multiturn_position_fusion_unit #(
    parameter int WINDOW_LEN = mpf_pkg::WINDOW_LEN_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Request channel.
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire mpf_pkg::in_item_t                 s_data,
    // Result channel.
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output mpf_pkg::out_item_t                     m_data,
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mpf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mpf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SAMPLE_W = mpf_pkg::SAMPLE_W;
    localparam int ANGLE_W  = mpf_pkg::ANGLE_W;
    localparam int COARSE_W = mpf_pkg::COARSE_W;
    localparam int POS_W    = mpf_pkg::POS_W;
    localparam int TURNS_W  = mpf_pkg::TURNS_W;

    localparam int  PTR_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int  FILL_W   = $clog2(WINDOW_LEN + 1);
    localparam int  SUM_W    = $clog2(mpf_pkg::SAMPLE_MAX * WINDOW_LEN + 1);
    localparam int  DIV_W    = (SUM_W > COARSE_W) ? SUM_W : COARSE_W;
    localparam int  WIN_LOG  = $clog2(WINDOW_LEN);
    localparam bit  WIN_POW2 = ((1 << WIN_LOG) == WINDOW_LEN);

    // Reciprocal of the window length, rounded up, scaled so that the
    // multiply and shift give the exact truncated average for every sum.
    localparam int  AVG_SHIFT = SUM_W + WIN_LOG;
    localparam int  AVG_RECIP = ((1 << AVG_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int  PROD_W    = 2 * SUM_W + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_AVG    = 3'd2;
    localparam logic [2:0] S_COARSE = 3'd4;
    localparam logic [2:0] S_DIVB   = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] pot_zero_reg;
    logic [ANGLE_W-1:0]  enc_zero_reg;
    logic [COARSE_W-1:0] turn_span_reg;
    logic                pot_reverse_reg;
    logic [COARSE_W-1:0] wrap_thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pot_zero_reg    <= '0;
            enc_zero_reg    <= '0;
            turn_span_reg   <= mpf_pkg::TURN_SPAN_RESET;
            pot_reverse_reg <= 1'b0;
            wrap_thr_reg    <= mpf_pkg::WRAP_THRESHOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mpf_pkg::REG_POT_ZERO:       pot_zero_reg    <= cfg_data[SAMPLE_W-1:0];
                mpf_pkg::REG_ENC_ZERO:       enc_zero_reg    <= cfg_data[ANGLE_W-1:0];
                mpf_pkg::REG_TURN_SPAN:      turn_span_reg   <= cfg_data;
                mpf_pkg::REG_POT_REVERSE:    pot_reverse_reg <= cfg_data[0];
                mpf_pkg::REG_WRAP_THRESHOLD: wrap_thr_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state and working registers.
    // ------------------------------------------------------------------
    logic [2:0]              state_reg;
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SAMPLE_W-1:0]     sample_reg;
    logic [ANGLE_W-1:0]      angle_in_reg;
    logic [SAMPLE_W-1:0]     avg_reg;
    logic [COARSE_W-1:0]     coarse_reg;
    logic [ANGLE_W-1:0]      angle_reg;
    logic signed [POS_W-1:0] last_pos_reg;
    logic signed [POS_W-1:0] res_pos_reg;
    logic [COARSE_W-1:0]     res_coarse_reg;
    logic                    m_valid_reg;
    mpf_pkg::out_item_t      m_data_reg;

    logic                    accept;
    logic                    out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // ------------------------------------------------------------------
    // Sample window: a ring buffer in a synchronous memory. The entry at the
    // write pointer is the oldest sample; it is read as the request is taken
    // and overwritten with the new sample in the cycle after. Until the window
    // has been filled once, the fill count makes the oldest entry read as
    // zero, which matches a cleared window.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] win_mem [WINDOW_LEN];
    logic [SAMPLE_W-1:0] win_rd_reg;
    logic                win_we;
    logic [SAMPLE_W-1:0] oldest;
    logic [PTR_W-1:0]    ptr_next;

    assign win_we = (state_reg == S_READ);

    always_ff @(posedge aclk) begin
        if (win_we) begin
            win_mem[wr_ptr_reg] <= sample_reg;
        end
        if (accept) begin
            win_rd_reg <= win_mem[wr_ptr_reg];
        end
    end

    assign oldest   = (fill_reg == FILL_W'(WINDOW_LEN)) ? win_rd_reg : '0;
    assign ptr_next = (wr_ptr_reg == PTR_W'(WINDOW_LEN - 1)) ? '0 : wr_ptr_reg + 1'b1;

    // Window average for a length that is not a power of two.
    logic [PROD_W-1:0] avg_prod;

    assign avg_prod = PROD_W'(sum_reg) * PROD_W'(AVG_RECIP);

    // ------------------------------------------------------------------
    // Coarse count, encoder angle and case selection.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0]     coarse_off;
    logic [COARSE_W-1:0]     coarse;
    logic [ANGLE_W-1:0]      angle;
    logic                    coarse_near;
    logic                    angle_high;
    logic                    use_turns;
    logic signed [POS_W-1:0] neg_pos;

    // A 12-bit difference wraps the offset into 0..4095 by itself.
    assign coarse_off  = avg_reg - pot_zero_reg;
    assign coarse      = pot_reverse_reg ? (mpf_pkg::FULL_SCALE - {1'b0, coarse_off})
                                         : {1'b0, coarse_off};
    assign angle       = angle_in_reg - enc_zero_reg;
    assign coarse_near = (coarse >= wrap_thr_reg);
    assign angle_high  = ({1'b0, angle} >= wrap_thr_reg);
    assign use_turns   = !coarse_near && !((coarse <= mpf_pkg::LOW_COARSE) && angle_high);
    // Angle minus one full turn: the angle below an all-ones sign extension.
    assign neg_pos     = {{(POS_W - ANGLE_W){1'b1}}, angle};

    // ------------------------------------------------------------------
    // Serial divider: coarse count by turn span.
    // ------------------------------------------------------------------
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic [COARSE_W-1:0] span;

    assign span         = (turn_span_reg == '0) ? COARSE_W'(1) : turn_span_reg;
    assign div_start    = (state_reg == S_COARSE) && use_turns;
    assign div_dividend = DIV_W'(coarse);
    assign div_divisor  = DIV_W'(span);

    mpf_divider #(
        .WIDTH    (DIV_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Turn selection from the step number. Odd steps straddle the low
    // angle border, even steps the high one.
    logic [COARSE_W-1:0] step;
    logic [TURNS_W-1:0]  half;
    logic [TURNS_W-1:0]  turns;

    assign step = div_quot[COARSE_W-1:0];
    assign half = step[COARSE_W-1:1];

    always_comb begin
        if (step[0]) begin
            turns = (angle_reg >= mpf_pkg::ANGLE_LOW) ? half : half + 1'b1;
        end else if (angle_reg <= mpf_pkg::ANGLE_HIGH) begin
            turns = half;
        end else if (step != '0) begin
            turns = half - 1'b1;
        end else begin
            turns = '0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            sum_reg      <= '0;
            last_pos_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // A new result may replace the one taken on this same edge.
            if (state_reg == S_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    sum_reg    <= sum_reg + SUM_W'(sample_reg) - SUM_W'(oldest);
                    wr_ptr_reg <= ptr_next;
                    if (fill_reg != FILL_W'(WINDOW_LEN)) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    state_reg <= S_AVG;
                end
                S_AVG: begin
                    state_reg <= S_COARSE;
                end
                S_COARSE: begin
                    state_reg <= use_turns ? S_DIVB : S_EMIT;
                end
                S_DIVB: begin
                    if (div_done) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        last_pos_reg <= res_pos_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg   <= s_data.pot_sample;
            angle_in_reg <= s_data.enc_angle;
        end
        if (state_reg == S_AVG) begin
            if (WIN_POW2) begin
                avg_reg <= SAMPLE_W'(sum_reg >> WIN_LOG);
            end else begin
                avg_reg <= SAMPLE_W'(avg_prod >> AVG_SHIFT);
            end
        end
        if (state_reg == S_COARSE) begin
            coarse_reg <= coarse;
            angle_reg  <= angle;
            if (coarse_near && angle_high) begin
                res_pos_reg    <= neg_pos;
                res_coarse_reg <= mpf_pkg::HOLD_COARSE;
            end else if (coarse_near) begin
                res_pos_reg    <= last_pos_reg;
                res_coarse_reg <= mpf_pkg::HOLD_COARSE;
            end else begin
                res_pos_reg    <= neg_pos;
                res_coarse_reg <= coarse;
            end
        end
        if (state_reg == S_DIVB && div_done) begin
            res_pos_reg    <= {1'b0, turns, angle_reg};
            res_coarse_reg <= coarse_reg;
        end
        if (state_reg == S_EMIT && out_free) begin
            m_data_reg.position     <= res_pos_reg;
            m_data_reg.coarse_count <= res_coarse_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request taken while another is in progress");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(WINDOW_LEN))
        else $error("window fill count beyond window length");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIVB))
        else $error("divider finished while no state waits for it");

    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && m_valid_reg && !m_ready) |=>
            (state_reg == S_EMIT && $stable(res_pos_reg)))
        else $error("finished result lost while the receiver stalls");

    a_coarse_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.coarse_count <= mpf_pkg::FULL_SCALE))
        else $error("coarse count out of range");

endmodule : multiturn_position_fusion_unit

`default_nettype wire

// ----- hdl/mpf_divider.sv -----
// ============================================================================
// mpf_divider: restoring unsigned divider, one quotient bit per cycle
// Loads on start, runs WIDTH steps and pulses done with the quotient ready.
// ============================================================================
`default_nettype none

module mpf_divider #(
    parameter int WIDTH = mpf_pkg::DIV_W_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  done,
    output logic [WIDTH-1:0]      quotient
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quot_reg;
    logic [WIDTH-1:0] dvsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   trial;

    // The trial subtraction decides one quotient bit per step.
    assign shifted = {rem_reg, quot_reg[WIDTH-1]};
    assign trial   = shifted - {1'b0, dvsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CNT_W'(WIDTH - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            dvsr_reg <= divisor;
        end else if (busy_reg) begin
            if (!trial[WIDTH]) begin
                rem_reg  <= trial[WIDTH-1:0];
                quot_reg <= {quot_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_reg  <= shifted[WIDTH-1:0];
                quot_reg <= {quot_reg[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule : mpf_divider

`default_nettype wire
